>>> src/aaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aaf_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int GROUP_W         = 17;
  localparam int PCT_W           = 16;
  localparam int ABS_W           = 32;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_INDEX_W     = 3;
  localparam int REASON_W        = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_DISCRETE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ADAPTIVE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_PCT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUGH_PCT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_ABS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUGH_ABS  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_GROUP  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK       = 3'd7;

  localparam logic [GROUP_W-1:0]  OWN_GROUP_RESET = 17'h1FFFE;
  localparam logic [REASON_W-1:0] MASK_RESET      = 4'hF;

  // 100 percent times 256 for the Q8.8 aperture.
  localparam logic [PCT_W-1:0] PCT_SCALE = 16'd25600;

  // Reason bit positions.
  localparam int RSN_VCHG   = 0;
  localparam int RSN_SMOOTH = 1;
  localparam int RSN_ROUGH  = 2;
  localparam int RSN_AUTO   = 3;

  typedef struct packed {
    logic start;     // word accepted: load working registers
    logic sub_en;    // subtract pass step
    logic sub_last;  // last subtract step: reload stored value
    logic cmp_en;    // compare pass step
  } ctrl_t;

  typedef struct packed {
    logic neq;
    logic gt_s_abs;
    logic gt_r_abs;
    logic gt_s_pct;
    logic gt_r_pct;
    logic mag_nz;
  } status_t;

endpackage
`default_nettype wire

>>> src/aaf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface aaf_in_if import aaf_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
  logic                      valid;
  logic                      ready;
  logic                      sample_valid;
  logic signed [VALUE_WIDTH-1:0] sample_value;
  logic signed [GROUP_W-1:0] current_group;

  modport source (output valid, output sample_valid, output sample_value,
                  output current_group, input ready);
  modport sink (input valid, input sample_valid, input sample_value,
                input current_group, output ready);
endinterface
`default_nettype wire

>>> src/aaf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface aaf_out_if ();
  logic valid;
  logic ready;
  logic archive;
  logic validity_changed;
  logic smooth_exceeded;
  logic rough_exceeded;
  logic auto_point;
  logic valid_now;

  modport source (output valid, output archive, output validity_changed,
                  output smooth_exceeded, output rough_exceeded,
                  output auto_point, output valid_now, input ready);
  modport sink (input valid, input archive, input validity_changed,
                input smooth_exceeded, input rough_exceeded,
                input auto_point, input valid_now, output ready);
endinterface
`default_nettype wire

>>> src/aaf_ser_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// LSB-first serial by parallel multiplier: one product bit per cycle while en is high.
module aaf_ser_mul import aaf_pkg::*; #(
  parameter int COEF_W = PCT_W
) (
  input  wire logic              clk,
  input  wire logic              clr,
  input  wire logic              en,
  input  wire logic              bit_in,
  input  wire logic [COEF_W-1:0] coef,
  output logic                   prod_bit
);

  logic [COEF_W-1:0] acc;
  logic [COEF_W:0]   sum;

  assign sum      = {1'b0, acc} + (bit_in ? {1'b0, coef} : {(COEF_W+1){1'b0}});
  assign prod_bit = sum[0];

  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (en) begin
      acc <= sum[COEF_W:1];
    end
  end

endmodule
`default_nettype wire

>>> src/aaf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial datapath. The first pass forms sample minus stored value and the
// neq flag; the second pass takes magnitudes and runs the threshold compares.
module aaf_datapath import aaf_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire ctrl_t                  ctrl,
  input  wire logic [VALUE_WIDTH-1:0] cur_value,
  input  wire logic [VALUE_WIDTH-1:0] st_value,
  input  wire logic [ABS_W-1:0]       smooth_abs,
  input  wire logic [ABS_W-1:0]       rough_abs,
  input  wire logic [PCT_W-1:0]       smooth_pct,
  input  wire logic [PCT_W-1:0]       rough_pct,
  output status_t                     status
);

  logic [VALUE_WIDTH-1:0] cur_sr;
  logic [VALUE_WIDTH-1:0] st_sr;
  logic [VALUE_WIDTH:0]   d_sr;
  logic [ABS_W-1:0]       sabs_sr;
  logic [ABS_W-1:0]       rabs_sr;
  logic                   carry;
  logic                   seen_d;
  logic                   seen_s;

  logic a_bit, b_bit, s_bit, c_next;
  logic dbit, mbit;
  logic pd_bit, ps_bit, pr_bit;

  assign a_bit  = cur_sr[0];
  assign b_bit  = st_sr[0];
  assign s_bit  = a_bit ^ ~b_bit ^ carry;
  assign c_next = (a_bit & ~b_bit) | (a_bit & carry) | (~b_bit & carry);

  // Serial abs: if negative, invert every bit above the first one.
  assign dbit = d_sr[0] ^ (d_sr[VALUE_WIDTH] & seen_d);
  assign mbit = st_sr[0] ^ (st_sr[VALUE_WIDTH-1] & seen_s);

  aaf_ser_mul #(.COEF_W(PCT_W)) u_mul_diff (
    .clk(clk), .clr(ctrl.start), .en(ctrl.cmp_en), .bit_in(dbit),
    .coef(PCT_SCALE), .prod_bit(pd_bit)
  );

  aaf_ser_mul #(.COEF_W(PCT_W)) u_mul_smooth (
    .clk(clk), .clr(ctrl.start), .en(ctrl.cmp_en), .bit_in(mbit),
    .coef(smooth_pct), .prod_bit(ps_bit)
  );

  aaf_ser_mul #(.COEF_W(PCT_W)) u_mul_rough (
    .clk(clk), .clr(ctrl.start), .en(ctrl.cmp_en), .bit_in(mbit),
    .coef(rough_pct), .prod_bit(pr_bit)
  );

  function automatic logic gt_step(input logic gt, input logic a, input logic b);
    gt_step = (a & ~b) | (gt & ~(a ^ b));
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cur_sr  <= cur_value;
      st_sr   <= st_value;
      sabs_sr <= smooth_abs;
      rabs_sr <= rough_abs;
      carry   <= 1'b1;
      seen_d  <= 1'b0;
      seen_s  <= 1'b0;
      status  <= '0;
    end else if (ctrl.sub_en) begin
      cur_sr     <= {cur_sr[VALUE_WIDTH-1], cur_sr[VALUE_WIDTH-1:1]};
      d_sr       <= {s_bit, d_sr[VALUE_WIDTH:1]};
      carry      <= c_next;
      status.neq <= status.neq | (a_bit ^ b_bit);
      if (ctrl.sub_last) begin
        st_sr <= st_value;
      end else begin
        st_sr <= {st_sr[VALUE_WIDTH-1], st_sr[VALUE_WIDTH-1:1]};
      end
    end else if (ctrl.cmp_en) begin
      d_sr            <= {d_sr[VALUE_WIDTH], d_sr[VALUE_WIDTH:1]};
      st_sr           <= {st_sr[VALUE_WIDTH-1], st_sr[VALUE_WIDTH-1:1]};
      sabs_sr         <= {1'b0, sabs_sr[ABS_W-1:1]};
      rabs_sr         <= {1'b0, rabs_sr[ABS_W-1:1]};
      seen_d          <= seen_d | d_sr[0];
      seen_s          <= seen_s | st_sr[0];
      status.mag_nz   <= status.mag_nz | mbit;
      status.gt_s_abs <= gt_step(status.gt_s_abs, dbit, sabs_sr[0]);
      status.gt_r_abs <= gt_step(status.gt_r_abs, dbit, rabs_sr[0]);
      status.gt_s_pct <= gt_step(status.gt_s_pct, pd_bit, ps_bit);
      status.gt_r_pct <= gt_step(status.gt_r_pct, pd_bit, pr_bit);
    end
  end

endmodule
`default_nettype wire

>>> src/aperture_archive_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted word passes through the subtract pass (ST_SUB) and the compare
// pass (ST_CMP) of the bit-serial datapath, then ST_FIN, where its result is
// registered. A new word is taken only in ST_IDLE, after the last left ST_FIN;
// it is taken while the previous result still waits in the output register.
// Reset (rst, synchronous, active high) clears the sequencer, the history
// flags and the stored value, and loads the register defaults.
module aperture_archive_filter_unit import aaf_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  aaf_in_if.sink                      sample_in,
  aaf_out_if.source                   result_out
);

  localparam int SUB_LEN = VALUE_WIDTH + 1;
  localparam int CMP_LEN = VALUE_WIDTH + 16;
  localparam int CNT_W   = $clog2(CMP_LEN + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUB  = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;

  logic                signal_is_discrete;
  logic                adaptive_mode;
  logic [PCT_W-1:0]    smooth_pct;
  logic [PCT_W-1:0]    rough_pct;
  logic [ABS_W-1:0]    smooth_abs;
  logic [ABS_W-1:0]    rough_abs;
  logic [GROUP_W-1:0]  own_group;
  logic [REASON_W-1:0] reason_mask;

  logic                   initialized;
  logic                   last_valid;
  logic [VALUE_WIDTH-1:0] archived_value;

  logic                   item_valid;
  logic [VALUE_WIDTH-1:0] item_value;
  logic [GROUP_W-1:0]     item_group;

  logic out_valid;
  logic out_archive, out_vchg, out_smooth, out_rough, out_auto, out_valid_now;

  ctrl_t   ctrl;
  status_t status;

  logic accept, sub_last, cmp_last, commit;
  logic r_vchg, r_smooth, r_rough, r_auto, r_arch;
  logic [REASON_W-1:0] reasons;

  assign sample_in.ready = (state == ST_IDLE);
  assign accept   = sample_in.valid && (state == ST_IDLE);
  assign sub_last = (state == ST_SUB) && (cnt == CNT_W'(SUB_LEN - 1));
  assign cmp_last = (state == ST_CMP) && (cnt == CNT_W'(CMP_LEN - 1));
  assign commit   = (state == ST_FIN) && (!out_valid || result_out.ready);

  assign ctrl.start    = accept;
  assign ctrl.sub_en   = (state == ST_SUB);
  assign ctrl.sub_last = sub_last;
  assign ctrl.cmp_en   = (state == ST_CMP);

  aaf_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_datapath (
    .clk(clk), .ctrl(ctrl), .cur_value(sample_in.sample_value),
    .st_value(archived_value), .smooth_abs(smooth_abs), .rough_abs(rough_abs),
    .smooth_pct(smooth_pct), .rough_pct(rough_pct), .status(status)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SUB;
      ST_SUB:  if (sub_last) state_next = ST_CMP;
      ST_CMP:  if (cmp_last) state_next = ST_FIN;
      ST_FIN:  if (commit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Decision for the word in flight; only meaningful in the final state.
  always_comb begin
    r_vchg   = !initialized || (item_valid != last_valid);
    r_smooth = 1'b0;
    r_rough  = 1'b0;
    if (!r_vchg && item_valid) begin
      if (signal_is_discrete) begin
        r_rough = status.neq;
      end else if (adaptive_mode) begin
        // A zero stored value counts as an exceeded aperture.
        r_smooth = !status.mag_nz || status.gt_s_pct;
        r_rough  = !status.mag_nz || status.gt_r_pct;
      end else begin
        r_smooth = status.gt_s_abs;
        r_rough  = status.gt_r_abs;
      end
    end
    r_auto = (item_group == own_group);
    reasons = '0;
    reasons[RSN_VCHG]   = r_vchg;
    reasons[RSN_SMOOTH] = r_smooth;
    reasons[RSN_ROUGH]  = r_rough;
    reasons[RSN_AUTO]   = r_auto;
    r_arch = |(reasons & reason_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept || sub_last || cmp_last) begin
        cnt <= '0;
      end else if (state == ST_SUB || state == ST_CMP) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      signal_is_discrete <= 1'b0;
      adaptive_mode      <= 1'b0;
      smooth_pct         <= '0;
      rough_pct          <= '0;
      smooth_abs         <= '0;
      rough_abs          <= '0;
      own_group          <= OWN_GROUP_RESET;
      reason_mask        <= MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DISCRETE:   signal_is_discrete <= cfg_data[0];
        REG_ADAPTIVE:   adaptive_mode      <= cfg_data[0];
        REG_SMOOTH_PCT: smooth_pct         <= cfg_data[PCT_W-1:0];
        REG_ROUGH_PCT:  rough_pct          <= cfg_data[PCT_W-1:0];
        REG_SMOOTH_ABS: smooth_abs         <= cfg_data[ABS_W-1:0];
        REG_ROUGH_ABS:  rough_abs          <= cfg_data[ABS_W-1:0];
        REG_OWN_GROUP:  own_group          <= cfg_data[GROUP_W-1:0];
        REG_MASK:       reason_mask        <= cfg_data[REASON_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initialized    <= 1'b0;
      last_valid     <= 1'b0;
      archived_value <= '0;
    end else if (commit) begin
      initialized <= 1'b1;
      last_valid  <= item_valid;
      if (r_arch) begin
        archived_value <= item_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_valid <= sample_in.sample_valid;
      item_value <= sample_in.sample_value;
      item_group <= sample_in.current_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_archive   <= r_arch;
      out_vchg      <= r_vchg;
      out_smooth    <= r_smooth;
      out_rough     <= r_rough;
      out_auto      <= r_auto;
      out_valid_now <= item_valid;
    end
  end

  assign result_out.valid            = out_valid;
  assign result_out.archive          = out_archive;
  assign result_out.validity_changed = out_vchg;
  assign result_out.smooth_exceeded  = out_smooth;
  assign result_out.rough_exceeded   = out_rough;
  assign result_out.auto_point       = out_auto;
  assign result_out.valid_now        = out_valid_now;

  // A result word must never overwrite one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    commit |-> (!out_valid || result_out.ready))
    else $error("result word overwritten");

  // After the first commit the history is marked as initialized.
  a_init_after_commit: assert property (@(posedge clk) disable iff (rst)
    commit |=> initialized)
    else $error("history not initialized after commit");

  // A validity change never comes together with an aperture reason.
  a_vchg_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_vchg && (out_smooth || out_rough)))
    else $error("validity change flagged with aperture reason");

  // The subtract pass hands over to the compare pass with a cleared counter.
  a_pass_handover: assert property (@(posedge clk) disable iff (rst)
    sub_last |=> (state == ST_CMP) && (cnt == '0))
    else $error("subtract pass did not hand over");

endmodule
`default_nettype wire
